FILE: hdl/mbp_pkg.sv
package mbp_pkg;

    localparam int CODE_W            = 64;
    localparam int LEN_W             = 7;
    localparam int BYTE_W            = 8;
    localparam int PEND_W            = 7;
    localparam int PCNT_W            = 3;
    localparam int MAX_CODE_BITS_DEF = 64;

    typedef enum logic {
        REQ_APPEND = 1'b0,
        REQ_FLUSH  = 1'b1
    } t_req;

    typedef struct packed {
        t_req                req_type;
        logic [CODE_W-1:0]   code_bits;
        logic [LEN_W-1:0]    code_length;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                last_of_run;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic align;
        logic shift;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic no_bytes;
        logic last_byte;
    } t_sts;

endpackage

FILE: hdl/mbp_ctrl.sv
module mbp_ctrl
    import mbp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_stall,
    output logic   o_out_valid,
    input  logic   i_out_stall,
    input  t_sts   i_sts,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                n_state = i_sts.no_bytes ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_out_stall && i_sts.last_byte) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_ALIGN: begin
                o_cmd.align = 1'b1;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                o_cmd.shift = !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: hdl/mbp_dpath.sv
module mbp_dpath
    import mbp_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_word   i_in_word,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output t_out_word  o_out_word
);

    localparam int W   = MAX_CODE_BITS + BYTE_W;  // pending + longest code fit
    localparam int CW  = $clog2(W);
    localparam int NBW = CW - 3;

    logic [W-1:0]      r_sr;
    logic [CW-1:0]     r_cnt;
    logic [NBW-1:0]    r_nb;
    logic [PEND_W-1:0] r_pend;
    logic [PCNT_W-1:0] r_pcnt;

    logic [LEN_W-1:0]  len_sat;
    logic [W-1:0]      code_mask;
    logic [W-1:0]      code_w;
    logic [W-1:0]      append_sr;
    logic [W-1:0]      flush_sr;
    logic [BYTE_W-1:0] flush_byte;
    logic [CW:0]       align_sh;
    logic [PCNT_W-1:0] rem;
    logic [PEND_W-1:0] rem_mask;

    assign len_sat = (i_in_word.code_length > LEN_W'(MAX_CODE_BITS)) ?
                     LEN_W'(MAX_CODE_BITS) : i_in_word.code_length;

    always_comb begin
        for (int i = 0; i < W; i++) begin
            code_mask[i] = (i < int'(len_sat));
        end
    end

    assign code_w     = W'(i_in_word.code_bits[MAX_CODE_BITS-1:0]) & code_mask;
    assign append_sr  = (W'(r_pend) << len_sat) | code_w;
    // flush: pad pending bits with zeros at the low end of one byte
    assign flush_byte = BYTE_W'({1'b0, r_pend} << (4'd8 - {1'b0, r_pcnt}));
    assign flush_sr   = W'(flush_byte);

    assign align_sh = (CW + 1)'(W) - {1'b0, r_cnt};
    assign rem      = r_cnt[2:0];
    assign rem_mask = (PEND_W'(1) << rem) - PEND_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (i_in_word.req_type == REQ_FLUSH) begin
                r_sr  <= flush_sr;
                r_cnt <= (r_pcnt != '0) ? CW'(BYTE_W) : '0;
            end else begin
                r_sr  <= append_sr;
                r_cnt <= CW'({1'b0, r_pcnt}) + CW'(len_sat);
            end
        end else if (i_cmd.align) begin
            // left-justify so the oldest bit sits at the top
            r_sr <= r_sr << align_sh;
            r_nb <= r_cnt[CW-1:3];
        end else if (i_cmd.shift) begin
            r_sr <= r_sr << BYTE_W;
            r_nb <= r_nb - NBW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_pcnt <= '0;
        end else if (i_cmd.load && i_in_word.req_type == REQ_FLUSH) begin
            r_pend <= '0;
            r_pcnt <= '0;
        end else if (i_cmd.align) begin
            // leftover bits are the low ones of the right-aligned stream
            r_pend <= r_sr[PEND_W-1:0] & rem_mask;
            r_pcnt <= rem;
        end
    end

    assign o_sts.no_bytes  = (r_cnt[CW-1:3] == '0);
    assign o_sts.last_byte = (r_nb == NBW'(1));

    assign o_out_word.out_byte    = r_sr[W-1 -: BYTE_W];
    assign o_out_word.last_of_run = (r_nb == NBW'(1));

endmodule

FILE: hdl/msb_first_bit_packer.sv
// Sequencing: an accepted word goes through the align state, then the emit
//   state raises output valid if any bytes are released; a new word is taken only in idle.
// Output: N = bytes released per word (0..8), one byte
//   per cycle on the output while not stalled; set by the align/emit sequencer.
// Reset: synchronous active-low; clears the sequencer and the pending bits,
//   output valid drops as the sequencer is reset to idle.
module msb_first_bit_packer
    import mbp_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_word  o_out_word
);

    t_cmd cmd;
    t_sts sts;

    mbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mbp_dpath #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_word (o_out_word)
    );

endmodule
